[design/bcsc_pkg.sv]
// Shared types and constants for the breath cycle stepper controller.
// Holds the item payload structs, phase and event codes, and register defaults.
// No dependencies; compiled first.
package bcsc_pkg;

  // Position register width is fixed by the position field of the result item.
  localparam int unsigned POS_W = 16;

  // Event kind carried by each input item
  typedef enum logic [1:0] {
    MODE_MS_TICK   = 2'd0,
    MODE_STEP_TICK = 2'd1,
    MODE_JOG       = 2'd2,
    MODE_NONE      = 2'd3
  } bcsc_mode_e;

  // Cycle phase
  typedef enum logic [2:0] {
    PH_STOP  = 3'd0,
    PH_WLOW  = 3'd1,
    PH_RISE  = 3'd2,
    PH_WHIGH = 3'd3,
    PH_FALL  = 3'd4,
    PH_MAN   = 3'd5
  } bcsc_phase_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_RISE_STEPS   = 3'd0,
    CFG_WAIT_LOW     = 3'd1,
    CFG_WAIT_HIGH    = 3'd2,
    CFG_PRESSURE_LIM = 3'd3,
    CFG_VOLUME_LIM   = 3'd4
  } bcsc_cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [14:0] RISE_STEPS_RST   = 15'd600;
  localparam logic [15:0] WAIT_LOW_RST     = 16'd2500;
  localparam logic [15:0] WAIT_HIGH_RST    = 16'd1500;
  localparam logic [11:0] PRESSURE_LIM_RST = 12'd2500;
  localparam logic [11:0] VOLUME_LIM_RST   = 12'd500;

  // Fall ends at or below this position
  localparam logic signed [POS_W-1:0] FALL_FLOOR = -16'sd30;

  // Automatic cycle always drives the main motor
  localparam logic [1:0] MAIN_MOTOR = 2'd1;
  localparam logic [1:0] LAST_MOTOR = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic               start_request;
    logic               home_switch;
    logic [11:0]        pressure_pa;
    logic [11:0]        volume_ml;
    logic signed [15:0] jog_steps;
    logic [1:0]         jog_motor;
  } bcsc_in_t;

  typedef struct packed {
    logic               step_pulse;
    logic               direction;
    logic [1:0]         pulse_motor;
    logic               motor_enable;
    logic [2:0]         phase;
    logic signed [15:0] position;
  } bcsc_out_t;

endpackage

[design/bcsc_chan_if.sv]
// Valid/ready channel carrying one item of payload type T.
// Uses no package; the payload type is given at instantiation.
interface bcsc_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[design/breath_cycle_stepper_controller.sv]
// Breath cycle stepper controller: ventilator phase machine for one stepper.
// An accepted item's result is registered in the main output register, or in the skid if it is held.
// Throughput: one item per cycle; a two-entry output buffer keeps input ready while
// one result waits, and input stalls only when both entries are full.
// Reset (async, active low): phase stopped, timers, position and jog cleared,
// configuration registers back to their defaults. Depends on bcsc_pkg, bcsc_chan_if.
module breath_cycle_stepper_controller #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bcsc_chan_if.sink                         in_i,
  bcsc_chan_if.source                       out_o,
  input  logic                              cfg_we_i,
  input  logic [bcsc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bcsc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned PW = bcsc_pkg::POS_W;

  // Configuration registers
  logic [14:0] rise_steps_q;
  logic [15:0] wait_low_q;
  logic [15:0] wait_high_q;
  logic [11:0] pres_lim_q;
  logic [11:0] vol_lim_q;

  // Controller state
  bcsc_pkg::bcsc_phase_e    phase_q, phase_d;
  logic [TIME_WIDTH-1:0]    ms_q, ms_e;
  logic [TIME_WIDTH-1:0]    pstart_q, pstart_d;
  logic                     clk_on_q, clk_on_e, clk_on_d;
  logic                     dir_q, dir_d;
  logic signed [PW-1:0]     pos_q, pos_step, pos_e;
  logic                     rise_q, rise_e, rise_d;
  logic                     fall_q, fall_e, fall_d;
  logic                     jog_act_q, jog_act_e;
  logic signed [15:0]       jog_rem_q, jog_rem_e;
  logic [1:0]               jog_tgt_q, jog_tgt_e;
  logic                     en_q, en_d;

  // Per-item results of the event stage
  logic       pulse;
  logic       pdir;
  logic [1:0] pmotor;

  // Output buffer
  bcsc_pkg::bcsc_out_t res_d, out_q, skid_q;
  logic                out_v_q, skid_v_q;
  logic                push, pop;

  bcsc_pkg::bcsc_in_t in_item;
  logic               start_req;
  logic               wlow_due, whigh_due, limit_hit;

  assign in_item   = in_i.payload;
  assign start_req = in_item.start_request;

  assign in_i.ready    = !skid_v_q;
  assign push          = in_i.valid && in_i.ready;
  assign pop           = out_v_q && out_o.ready;
  assign out_o.valid   = out_v_q;
  assign out_o.payload = out_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_steps_q <= bcsc_pkg::RISE_STEPS_RST;
      wait_low_q   <= bcsc_pkg::WAIT_LOW_RST;
      wait_high_q  <= bcsc_pkg::WAIT_HIGH_RST;
      pres_lim_q   <= bcsc_pkg::PRESSURE_LIM_RST;
      vol_lim_q    <= bcsc_pkg::VOLUME_LIM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bcsc_pkg::CFG_RISE_STEPS:   rise_steps_q <= cfg_data_i[14:0];
        bcsc_pkg::CFG_WAIT_LOW:     wait_low_q   <= cfg_data_i;
        bcsc_pkg::CFG_WAIT_HIGH:    wait_high_q  <= cfg_data_i;
        bcsc_pkg::CFG_PRESSURE_LIM: pres_lim_q   <= cfg_data_i[11:0];
        bcsc_pkg::CFG_VOLUME_LIM:   vol_lim_q    <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Event stage: tick, step or jog load, then home switch clears position
  always_comb begin
    ms_e      = ms_q;
    clk_on_e  = clk_on_q;
    jog_act_e = jog_act_q;
    jog_rem_e = jog_rem_q;
    jog_tgt_e = jog_tgt_q;
    rise_e    = rise_q;
    fall_e    = fall_q;
    pos_step  = pos_q;
    pulse     = 1'b0;
    pdir      = 1'b0;
    pmotor    = bcsc_pkg::MAIN_MOTOR;
    unique case (in_item.mode)
      bcsc_pkg::MODE_MS_TICK: begin
        ms_e = ms_q + TIME_WIDTH'(1);
      end
      bcsc_pkg::MODE_STEP_TICK: begin
        if (clk_on_q) begin
          if (jog_act_q) begin
            // jog has priority over the cycle and leaves position alone
            if (jog_rem_q > 16'sd0) begin
              pulse     = 1'b1;
              pmotor    = jog_tgt_q;
              jog_rem_e = jog_rem_q - 16'sd1;
            end else if (jog_rem_q < 16'sd0) begin
              pulse     = 1'b1;
              pdir      = 1'b1;
              pmotor    = jog_tgt_q;
              jog_rem_e = jog_rem_q + 16'sd1;
            end else begin
              jog_act_e = 1'b0;
            end
          end else if (!dir_q) begin
            pulse    = 1'b1;
            pos_step = pos_q + 16'sd1;
            if (pos_step >= $signed({1'b0, rise_steps_q})) begin
              rise_e   = 1'b1;
              clk_on_e = 1'b0;
            end
          end else begin
            pulse    = 1'b1;
            pdir     = 1'b1;
            pos_step = pos_q - 16'sd1;
            if (in_item.home_switch || pos_step <= bcsc_pkg::FALL_FLOOR) begin
              fall_e   = 1'b1;
              clk_on_e = 1'b0;
            end
          end
        end
      end
      bcsc_pkg::MODE_JOG: begin
        jog_rem_e = in_item.jog_steps;
        jog_tgt_e = (in_item.jog_motor == 2'd0) ? bcsc_pkg::LAST_MOTOR : in_item.jog_motor;
        jog_act_e = 1'b1;
      end
      default: ;
    endcase
    pos_e = in_item.home_switch ? '0 : pos_step;
  end

  // Deadline and limit checks
  assign wlow_due  = ms_e >= (pstart_q + TIME_WIDTH'(wait_low_q));
  assign whigh_due = ms_e >= (pstart_q + TIME_WIDTH'(wait_high_q));
  assign limit_hit = (in_item.pressure_pa >= pres_lim_q) || (in_item.volume_ml >= vol_lim_q);

  // Phase next state
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      bcsc_pkg::PH_STOP: begin
        if (start_req) phase_d = bcsc_pkg::PH_WLOW;
        if (jog_act_e) phase_d = bcsc_pkg::PH_MAN;
      end
      bcsc_pkg::PH_WLOW: begin
        if (wlow_due) phase_d = bcsc_pkg::PH_RISE;
        if (!start_req) phase_d = bcsc_pkg::PH_STOP;
      end
      bcsc_pkg::PH_RISE: begin
        if (rise_e || limit_hit) phase_d = bcsc_pkg::PH_WHIGH;
        if (!start_req) phase_d = bcsc_pkg::PH_STOP;
      end
      bcsc_pkg::PH_WHIGH: begin
        if (whigh_due) phase_d = bcsc_pkg::PH_FALL;
        if (!start_req) phase_d = bcsc_pkg::PH_STOP;
      end
      bcsc_pkg::PH_FALL: begin
        if (fall_e) phase_d = bcsc_pkg::PH_WLOW;
        if (!start_req) phase_d = bcsc_pkg::PH_STOP;
      end
      default: begin
        if (!jog_act_e) phase_d = bcsc_pkg::PH_STOP;
      end
    endcase
  end

  // Phase actions on enable, step clock, direction, timer and done flags
  always_comb begin
    en_d     = en_q;
    clk_on_d = clk_on_e;
    dir_d    = dir_q;
    pstart_d = pstart_q;
    rise_d   = rise_e;
    fall_d   = fall_e;
    unique case (phase_q)
      bcsc_pkg::PH_STOP: begin
        en_d = start_req;
        if (start_req) pstart_d = ms_e;
        if (jog_act_e) begin
          clk_on_d = 1'b1;
          en_d     = 1'b1;
        end
      end
      bcsc_pkg::PH_WLOW: begin
        if (wlow_due) begin
          dir_d    = 1'b0;
          clk_on_d = 1'b1;
        end
        if (!start_req) clk_on_d = 1'b0;
      end
      bcsc_pkg::PH_RISE: begin
        if (rise_e) begin
          rise_d   = 1'b0;
          pstart_d = ms_e;
        end
        if (limit_hit) begin
          pstart_d = ms_e;
          clk_on_d = 1'b0;
        end
        if (!start_req) clk_on_d = 1'b0;
      end
      bcsc_pkg::PH_WHIGH: begin
        if (whigh_due) begin
          dir_d    = 1'b1;
          clk_on_d = 1'b1;
          pstart_d = ms_e;
        end
        if (!start_req) clk_on_d = 1'b0;
      end
      bcsc_pkg::PH_FALL: begin
        if (fall_e) fall_d = 1'b0;
        if (!start_req) clk_on_d = 1'b0;
      end
      default: begin
        if (!jog_act_e) clk_on_d = 1'b0;
      end
    endcase
  end

  // Result item
  always_comb begin
    res_d.step_pulse   = pulse;
    res_d.direction    = pulse ? pdir : dir_d;
    res_d.pulse_motor  = pmotor;
    res_d.motor_enable = en_d;
    res_d.phase        = phase_d;
    res_d.position     = pos_e;
  end

  // State registers, updated once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= bcsc_pkg::PH_STOP;
      ms_q      <= '0;
      pstart_q  <= '0;
      clk_on_q  <= 1'b0;
      dir_q     <= 1'b0;
      pos_q     <= '0;
      rise_q    <= 1'b0;
      fall_q    <= 1'b0;
      jog_act_q <= 1'b0;
      jog_rem_q <= '0;
      jog_tgt_q <= bcsc_pkg::MAIN_MOTOR;
      en_q      <= 1'b0;
    end else if (push) begin
      phase_q   <= phase_d;
      ms_q      <= ms_e;
      pstart_q  <= pstart_d;
      clk_on_q  <= clk_on_d;
      dir_q     <= dir_d;
      pos_q     <= pos_e;
      rise_q    <= rise_d;
      fall_q    <= fall_d;
      jog_act_q <= jog_act_e;
      jog_rem_q <= jog_rem_e;
      jog_tgt_q <= jog_tgt_e;
      en_q      <= en_d;
    end
  end

  // Two-entry output buffer: main register plus skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) skid_v_q <= 1'b0;
    end else if (push) begin
      if (out_v_q && !pop) skid_v_q <= 1'b1;
      else out_v_q <= 1'b1;
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (out_v_q && !pop) skid_q <= res_d;
      else out_q <= res_d;
    end
  end

  // Checks
  a_skid_implies_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid entry held without main entry");

  a_manual_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == bcsc_pkg::PH_MAN |-> en_q) else $error("manual phase with motors off");

  a_stop_clock_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == bcsc_pkg::PH_STOP |-> !clk_on_q) else $error("step clock on while stopped");

  a_rise_dir_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == bcsc_pkg::PH_RISE |-> !dir_q) else $error("rise phase moving down");

  a_jog_motor_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.pulse_motor != bcsc_pkg::MAIN_MOTOR |-> out_q.step_pulse)
    else $error("non-main motor selected without a pulse");

endmodule
